@@ src/s2d_pkg.sv @@
// Shared types and constants for the sparse-to-dense component map.
package s2d_pkg;

	localparam int REQ_W    = 2;
	localparam int KIND_W   = 5;
	localparam int IDX_W    = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 5;
	localparam int COUNT_W  = 5;
	localparam int PAIR_W   = 2 * IDX_W;

	// slot reported when a kind has no slot
	localparam logic [SLOT_W-1:0] SLOT_NONE = 5'd31;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_PRESENT = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	// which result the datapath captures
	typedef enum logic [2:0] {
		RES_HOLD,
		RES_NOP,
		RES_ABSENT,
		RES_FULL,
		RES_PRESENT,
		RES_ADDED,
		RES_PAIR
	} res_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_KEY,
		S_EVAL,
		S_LK_RD,
		S_RM_RD,
		S_SCAN,
		S_RM_FIN,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     latch_req;
		logic     key_rd;
		logic     key_save;
		logic     add_wr;
		logic     slot_rd_key;
		logic     slot_rd_last;
		logic     scan_start;
		logic     scan_rd;
		logic     move_wr;
		logic     remove_commit;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_nop;
		logic is_add;
		logic is_lookup;
		logic kind_oob;
		logic full;
		logic present;
		logic held;
		logic key_is_last;
		logic scan_hit;
		logic scan_done;
		logic check_pend;
	} sts_t;

endpackage

@@ src/s2d_dpath.sv @@
// Datapath: kind key memory, dense pair memory, fill count, owner scan and result registers.
module s2d_dpath #(
	parameter int NUM_KINDS = 32,
	parameter int MAX_SLOTS = 16,
	parameter int KEY_WIDTH = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [s2d_pkg::REQ_W-1:0]     req_type,
	input  logic [s2d_pkg::KIND_W-1:0]    component_kind,
	input  logic [s2d_pkg::IDX_W-1:0]     chunk_index,
	input  logic [s2d_pkg::IDX_W-1:0]     element_index,
	input  s2d_pkg::cmd_t                 cmd,
	output s2d_pkg::sts_t                 sts,
	output logic [s2d_pkg::STATUS_W-1:0]  status,
	output logic [s2d_pkg::SLOT_W-1:0]    slot,
	output logic [s2d_pkg::IDX_W-1:0]     found_chunk,
	output logic [s2d_pkg::IDX_W-1:0]     found_element,
	output logic [s2d_pkg::COUNT_W-1:0]   entry_count
);

	localparam int KIDX_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
	localparam int KEXT_W = ((KIDX_W > s2d_pkg::KIND_W) ? KIDX_W : s2d_pkg::KIND_W) + 1;
	localparam int SCNT_W = $clog2(NUM_KINDS + 1);
	localparam int SIDX_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W  = ((KEY_WIDTH > CNT_W) ? KEY_WIDTH : CNT_W) + 1;
	localparam logic [KEY_WIDTH-1:0] KeyEmpty = {KEY_WIDTH{1'b1}};

	// latched request
	s2d_pkg::req_t                 req_q;
	logic [s2d_pkg::KIND_W-1:0]    kind_q;
	logic [s2d_pkg::IDX_W-1:0]     chunk_q;
	logic [s2d_pkg::IDX_W-1:0]     elem_q;

	// kind key memory plus per-kind valid bits (invalid reads as empty)
	logic [KEY_WIDTH-1:0]          key_mem [NUM_KINDS];
	logic [NUM_KINDS-1:0]          key_vld_q;
	logic [KEY_WIDTH-1:0]          key_rd_q;
	logic                          key_rd_vld_q;
	logic [KEY_WIDTH-1:0]          key_q;

	// dense pair memory; entries at or above the fill count are never read
	logic [s2d_pkg::PAIR_W-1:0]    slot_mem [MAX_SLOTS];
	logic [s2d_pkg::PAIR_W-1:0]    slot_rd_q;
	logic [CNT_W-1:0]              used_q;

	// owner scan
	logic [SCNT_W-1:0]             scan_q;
	logic [KIDX_W-1:0]             scan_addr_s1;
	logic                          check_s1;

	// result and output registers
	s2d_pkg::status_t              res_status_q;
	logic [s2d_pkg::SLOT_W-1:0]    res_slot_q;
	logic [s2d_pkg::IDX_W-1:0]     res_chunk_q;
	logic [s2d_pkg::IDX_W-1:0]     res_elem_q;
	logic [s2d_pkg::STATUS_W-1:0]  out_status_q;
	logic [s2d_pkg::SLOT_W-1:0]    out_slot_q;
	logic [s2d_pkg::IDX_W-1:0]     out_chunk_q;
	logic [s2d_pkg::IDX_W-1:0]     out_elem_q;
	logic [s2d_pkg::COUNT_W-1:0]   out_count_q;

	logic [KEXT_W-1:0]             kind_ext;
	logic [KIDX_W-1:0]             kind_idx;
	logic                          kind_oob;
	logic [KEY_WIDTH-1:0]          key_val;
	logic [CMP_W-1:0]              key_val_c;
	logic [CMP_W-1:0]              key_c;
	logic [CMP_W-1:0]              used_c;
	logic [CMP_W-1:0]              max_c;
	logic [CMP_W-1:0]              last_c;
	logic                          full;
	logic                          present;
	logic                          scan_done;
	logic                          scan_issue;
	logic                          key_rd_en;
	logic [KIDX_W-1:0]             key_rd_idx;
	logic                          key_wr_en;
	logic [KIDX_W-1:0]             key_wr_idx;
	logic [KEY_WIDTH-1:0]          key_wr_data;
	logic                          slot_rd_en;
	logic [SIDX_W-1:0]             slot_rd_idx;
	logic                          slot_wr_en;
	logic [SIDX_W-1:0]             slot_wr_idx;
	logic [s2d_pkg::PAIR_W-1:0]    slot_wr_data;

	// decode and compares
	always_comb begin
		kind_ext  = KEXT_W'(kind_q);
		kind_oob  = kind_ext >= KEXT_W'(NUM_KINDS);
		kind_idx  = kind_ext[KIDX_W-1:0];
		key_val   = key_rd_vld_q ? key_rd_q : KeyEmpty;
		key_val_c = CMP_W'(key_val);
		key_c     = CMP_W'(key_q);
		used_c    = CMP_W'(used_q);
		max_c     = CMP_W'(MAX_SLOTS);
		last_c    = used_c - CMP_W'(1);
		full      = used_q >= CNT_W'(MAX_SLOTS);
		present   = key_val != KeyEmpty;
		scan_done = scan_q == SCNT_W'(NUM_KINDS);
		scan_issue = cmd.scan_rd && !scan_done;

		sts.is_nop      = req_q == s2d_pkg::REQ_NOP;
		sts.is_add      = req_q == s2d_pkg::REQ_ADD;
		sts.is_lookup   = req_q == s2d_pkg::REQ_LOOKUP;
		sts.kind_oob    = kind_oob;
		sts.full        = full;
		sts.present     = present;
		sts.held        = present && (key_val_c < max_c) && (key_val_c < used_c);
		sts.key_is_last = key_c == last_c;
		sts.scan_hit    = check_s1 && (key_val_c == last_c);
		sts.scan_done   = scan_done;
		sts.check_pend  = check_s1;
	end

	// memory port steering
	always_comb begin
		key_rd_en   = cmd.key_rd || scan_issue;
		key_rd_idx  = cmd.scan_rd ? scan_q[KIDX_W-1:0] : kind_idx;
		key_wr_en   = cmd.add_wr || cmd.move_wr;
		key_wr_idx  = cmd.move_wr ? scan_addr_s1 : kind_idx;
		key_wr_data = cmd.move_wr ? key_q : KEY_WIDTH'(used_q);

		slot_rd_en   = cmd.slot_rd_key || cmd.slot_rd_last;
		slot_rd_idx  = cmd.slot_rd_last ? last_c[SIDX_W-1:0] : key_val_c[SIDX_W-1:0];
		slot_wr_en   = cmd.add_wr || cmd.move_wr;
		slot_wr_idx  = cmd.move_wr ? key_c[SIDX_W-1:0] : used_q[SIDX_W-1:0];
		slot_wr_data = cmd.move_wr ? slot_rd_q : {chunk_q, elem_q};
	end

	// key memory
	always_ff @(posedge clk) begin
		if (key_wr_en) begin
			key_mem[key_wr_idx] <= key_wr_data;
		end
		if (key_rd_en) begin
			key_rd_q     <= key_mem[key_rd_idx];
			key_rd_vld_q <= key_vld_q[key_rd_idx];
		end
	end

	// pair memory
	always_ff @(posedge clk) begin
		if (slot_wr_en) begin
			slot_mem[slot_wr_idx] <= slot_wr_data;
		end
		if (slot_rd_en) begin
			slot_rd_q <= slot_mem[slot_rd_idx];
		end
	end

	// key valid bits, fill count, scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_vld_q <= '0;
			used_q    <= '0;
			scan_q    <= '0;
			check_s1  <= 1'b0;
		end else begin
			if (cmd.add_wr) begin
				key_vld_q[kind_idx] <= 1'b1;
				used_q              <= used_q + CNT_W'(1);
			end else if (cmd.remove_commit) begin
				key_vld_q[kind_idx] <= 1'b0;
				used_q              <= used_q - CNT_W'(1);
			end
			if (cmd.scan_start) begin
				scan_q   <= '0;
				check_s1 <= 1'b0;
			end else if (cmd.scan_rd) begin
				check_s1 <= scan_issue;
				if (scan_issue) begin
					scan_q <= scan_q + SCNT_W'(1);
				end
			end
		end
	end

	// request latch and scan address pipeline
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q   <= s2d_pkg::req_t'(req_type);
			kind_q  <= component_kind;
			chunk_q <= chunk_index;
			elem_q  <= element_index;
		end
		if (cmd.key_save) begin
			key_q <= key_val;
		end
		if (scan_issue) begin
			scan_addr_s1 <= scan_q[KIDX_W-1:0];
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		unique case (cmd.res_sel)
			s2d_pkg::RES_HOLD: begin
			end
			s2d_pkg::RES_NOP: begin
				res_status_q <= s2d_pkg::ST_OK;
				res_slot_q   <= s2d_pkg::SLOT_NONE;
				res_chunk_q  <= '0;
				res_elem_q   <= '0;
			end
			s2d_pkg::RES_ABSENT: begin
				res_status_q <= s2d_pkg::ST_ABSENT;
				res_slot_q   <= s2d_pkg::SLOT_NONE;
				res_chunk_q  <= '0;
				res_elem_q   <= '0;
			end
			s2d_pkg::RES_FULL: begin
				res_status_q <= s2d_pkg::ST_FULL;
				res_slot_q   <= s2d_pkg::SLOT_NONE;
				res_chunk_q  <= '0;
				res_elem_q   <= '0;
			end
			s2d_pkg::RES_PRESENT: begin
				res_status_q <= s2d_pkg::ST_PRESENT;
				res_slot_q   <= s2d_pkg::SLOT_W'(key_val_c);
				res_chunk_q  <= '0;
				res_elem_q   <= '0;
			end
			s2d_pkg::RES_ADDED: begin
				res_status_q <= s2d_pkg::ST_OK;
				res_slot_q   <= s2d_pkg::SLOT_W'(used_q);
				res_chunk_q  <= chunk_q;
				res_elem_q   <= elem_q;
			end
			s2d_pkg::RES_PAIR: begin
				res_status_q <= s2d_pkg::ST_OK;
				res_slot_q   <= s2d_pkg::SLOT_W'(key_c);
				res_chunk_q  <= slot_rd_q[s2d_pkg::PAIR_W-1:s2d_pkg::IDX_W];
				res_elem_q   <= slot_rd_q[s2d_pkg::IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// output register, count taken after the request's commit
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_chunk_q  <= res_chunk_q;
			out_elem_q   <= res_elem_q;
			out_count_q  <= s2d_pkg::COUNT_W'(used_q);
		end
	end

	assign status        = out_status_q;
	assign slot          = out_slot_q;
	assign found_chunk   = out_chunk_q;
	assign found_element = out_elem_q;
	assign entry_count   = out_count_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_SLOTS))
		else $error("fill count beyond table size");

	a_add_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |-> (!full && !present && !kind_oob))
		else $error("add committed on full table or present kind");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |=> (used_q == CNT_W'($past(used_q) + CNT_W'(1))))
		else $error("fill count did not advance on add");

	a_move_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move_wr |-> (sts.scan_hit && !sts.key_is_last))
		else $error("swap move without owner hit");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove_commit |-> (used_q != '0))
		else $error("remove committed on empty table");

endmodule

@@ src/s2d_ctrl.sv @@
// Controller: request sequencing state machine and output valid.
module s2d_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  s2d_pkg::sts_t sts,
	output s2d_pkg::cmd_t cmd
);

	s2d_pkg::state_t state_q;
	s2d_pkg::state_t state_nxt;
	logic            out_valid_q;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= s2d_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.res_sel = s2d_pkg::RES_HOLD;
		unique case (state_q)
			s2d_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					state_nxt     = s2d_pkg::S_RD_KEY;
				end
			end
			s2d_pkg::S_RD_KEY: begin
				cmd.key_rd = 1'b1;
				state_nxt  = s2d_pkg::S_EVAL;
			end
			s2d_pkg::S_EVAL: begin
				cmd.key_save = 1'b1;
				state_nxt    = s2d_pkg::S_FINISH;
				if (sts.is_nop) begin
					cmd.res_sel = s2d_pkg::RES_NOP;
				end else if (sts.kind_oob) begin
					cmd.res_sel = s2d_pkg::RES_ABSENT;
				end else if (sts.is_add) begin
					// full check goes before presence check
					if (sts.full) begin
						cmd.res_sel = s2d_pkg::RES_FULL;
					end else if (sts.present) begin
						cmd.res_sel = s2d_pkg::RES_PRESENT;
					end else begin
						cmd.add_wr  = 1'b1;
						cmd.res_sel = s2d_pkg::RES_ADDED;
					end
				end else if (!sts.held) begin
					cmd.res_sel = s2d_pkg::RES_ABSENT;
				end else begin
					cmd.slot_rd_key = 1'b1;
					state_nxt = sts.is_lookup ? s2d_pkg::S_LK_RD : s2d_pkg::S_RM_RD;
				end
			end
			s2d_pkg::S_LK_RD: begin
				cmd.res_sel = s2d_pkg::RES_PAIR;
				state_nxt   = s2d_pkg::S_FINISH;
			end
			s2d_pkg::S_RM_RD: begin
				// capture removed pair; fetch last slot if a swap is needed
				cmd.res_sel = s2d_pkg::RES_PAIR;
				if (sts.key_is_last) begin
					state_nxt = s2d_pkg::S_RM_FIN;
				end else begin
					cmd.slot_rd_last = 1'b1;
					cmd.scan_start   = 1'b1;
					state_nxt        = s2d_pkg::S_SCAN;
				end
			end
			s2d_pkg::S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_hit) begin
					cmd.move_wr = 1'b1;
					state_nxt   = s2d_pkg::S_RM_FIN;
				end else if (sts.scan_done && !sts.check_pend) begin
					// no owner found: skip the move
					state_nxt = s2d_pkg::S_RM_FIN;
				end
			end
			s2d_pkg::S_RM_FIN: begin
				cmd.remove_commit = 1'b1;
				state_nxt         = s2d_pkg::S_FINISH;
			end
			s2d_pkg::S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nxt    = s2d_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = s2d_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall  = state_q != s2d_pkg::S_IDLE;
	assign out_valid = out_valid_q;

	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.add_wr, cmd.move_wr, cmd.remove_commit}) <= 1)
		else $error("more than one table update in a cycle");

	a_load_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (out_valid && state_q == s2d_pkg::S_IDLE))
		else $error("result load did not raise output valid");

	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == s2d_pkg::S_SCAN && $past(state_q) != s2d_pkg::S_SCAN)
		|-> ($past(state_q) == s2d_pkg::S_RM_RD))
		else $error("owner scan entered outside remove");

endmodule

@@ src/sparse_to_dense_component_map.sv @@
// Top level of the sparse-to-dense component map.
// Each item is one request (add, remove or look up a component kind) and gives exactly
// one result item. Items are handled one at a time. An add, and any item answered with
// an error status or ignored, is settled once its kind key is read. A lookup of a held
// kind also reads its dense pair, and a remove reads the pair and then commits. A remove
// of any slot but the last also runs the owner search, which reads the kind key memory
// one key per cycle to find the kind holding the last dense slot.
// A finished result sits in an output register, so the next item is accepted while it
// waits. That next item then holds in its final state until the older result is taken,
// so output stalls add to its time. Kind keys come out of reset empty through per-kind
// valid bits; there is no clearing pass, and the block is ready right after reset.
module sparse_to_dense_component_map #(
	parameter int NUM_KINDS = 32,
	parameter int MAX_SLOTS = 16,
	parameter int KEY_WIDTH = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [s2d_pkg::REQ_W-1:0]     req_type,
	input  logic [s2d_pkg::KIND_W-1:0]    component_kind,
	input  logic [s2d_pkg::IDX_W-1:0]     chunk_index,
	input  logic [s2d_pkg::IDX_W-1:0]     element_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [s2d_pkg::STATUS_W-1:0]  status,
	output logic [s2d_pkg::SLOT_W-1:0]    slot,
	output logic [s2d_pkg::IDX_W-1:0]     found_chunk,
	output logic [s2d_pkg::IDX_W-1:0]     found_element,
	output logic [s2d_pkg::COUNT_W-1:0]   entry_count
);

	s2d_pkg::cmd_t cmd;
	s2d_pkg::sts_t sts;

	s2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	s2d_dpath #(
		.NUM_KINDS (NUM_KINDS),
		.MAX_SLOTS (MAX_SLOTS),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_type       (req_type),
		.component_kind (component_kind),
		.chunk_index    (chunk_index),
		.element_index  (element_index),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.slot           (slot),
		.found_chunk    (found_chunk),
		.found_element  (found_element),
		.entry_count    (entry_count)
	);

endmodule
